// ===== hw/rtl/kctq_pkg.sv =====
// Shared constants, codes and types of the keyed count table.
`default_nettype none

package kctq_pkg;

   // Table geometry
   localparam int SLOTS = 128;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   // Field widths
   localparam int ACT_W  = 2;
   localparam int KEY_W  = 16;
   localparam int AMT_W  = 16;
   localparam int TOT_W  = 16;
   localparam int AOUT_W = 17;
   localparam int STAT_W = 3;
   localparam int ALU_W  = 17;

   // Actions
   localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
   localparam logic [STAT_W-1:0] ST_OVER    = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STAT_W-1:0] ST_MISSING = 3'd3;
   localparam logic [STAT_W-1:0] ST_SHORT   = 3'd4;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] res;
      logic             borrow;
      logic             zero;
   } alu_rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [AMT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        entry;
   } mem_wr_type;

endpackage

`default_nettype wire

// ===== hw/rtl/kctq_alu.sv =====
// Shared add/subtract unit with borrow and zero flags.
`default_nettype none

module kctq_alu (
   input  kctq_pkg::alu_req_type req,
   output kctq_pkg::alu_rsp_type rsp
);
   import kctq_pkg::*;

   logic [ALU_W:0] wide;

   always_comb begin
      if (req.op == ALU_SUB) begin
         wide = {1'b0, req.a} - {1'b0, req.b};
      end else begin
         wide = {1'b0, req.a} + {1'b0, req.b};
      end
      rsp.res    = wide[ALU_W-1:0];
      rsp.borrow = wide[ALU_W];
      rsp.zero   = (wide[ALU_W-1:0] == '0);
   end

endmodule

`default_nettype wire

// ===== hw/rtl/kctq_mem.sv =====
// Entry store: key and count per slot, one write and one registered read.
`default_nettype none

module kctq_mem (
   input  logic                         clock,
   input  kctq_pkg::mem_wr_type         wr,
   input  logic [kctq_pkg::IDX_W-1:0]   rd_addr,
   output kctq_pkg::entry_type          rd_entry
);
   import kctq_pkg::*;

   entry_type store_mem [SLOTS];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_mem[wr.addr] <= wr.entry;
      end
      rd_entry_ff <= store_mem[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/kctq_ctrl.sv =====
// Sequencer: key scan, quota check, entry update and result register.
`default_nettype none

module kctq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [kctq_pkg::ACT_W-1:0]    req_action,
   input  logic [kctq_pkg::KEY_W-1:0]    req_item_key,
   input  logic [kctq_pkg::AMT_W-1:0]    req_amount,
   input  logic [kctq_pkg::TOT_W-1:0]    capacity,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [kctq_pkg::STAT_W-1:0]   rsp_status,
   output logic [kctq_pkg::AOUT_W-1:0]   rsp_amount_out,
   output logic                          rsp_has_enough,
   output logic [kctq_pkg::TOT_W-1:0]    rsp_total_now,
   output kctq_pkg::alu_req_type         alu_req,
   input  kctq_pkg::alu_rsp_type         alu_rsp,
   output kctq_pkg::mem_wr_type          mem_wr,
   output logic [kctq_pkg::IDX_W-1:0]    mem_rd_addr,
   input  kctq_pkg::entry_type           mem_rd_entry
);
   import kctq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SUM,
      S_CAP,
      S_SCAN,
      S_MERGE,
      S_APPEND,
      S_TAKE,
      S_SHORT,
      S_DRAIN,
      S_PEEK,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [ACT_W-1:0]   action_ff, action_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [AMT_W-1:0]   amt_ff, amt_in;
   logic [ALU_W-1:0]   sum_ff, sum_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [AMT_W-1:0]   cnt_ff, cnt_in;
   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   logic [AOUT_W-1:0]  res_aout_ff, res_aout_in;
   logic               res_enough_ff, res_enough_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [AOUT_W-1:0]  rsp_aout_ff, rsp_aout_in;
   logic               rsp_enough_ff, rsp_enough_in;
   logic [TOT_W-1:0]   rsp_total_ff, rsp_total_in;

   logic scan_hit;
   logic scan_end;

   // operand steering for the shared unit
   always_comb begin
      alu_req.op = ALU_ADD;
      alu_req.a  = '0;
      alu_req.b  = '0;
      case (state_ff)
         S_SUM: begin
            alu_req.a = {1'b0, total_ff};
            alu_req.b = {1'b0, amt_ff};
         end
         S_CAP: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = sum_ff;
            alu_req.b  = {1'b0, capacity};
         end
         S_SCAN: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {1'b0, mem_rd_entry.key};
            alu_req.b  = {1'b0, key_ff};
         end
         S_MERGE: begin
            alu_req.a = {1'b0, cnt_ff};
            alu_req.b = {1'b0, amt_ff};
         end
         S_TAKE, S_PEEK: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {1'b0, cnt_ff};
            alu_req.b  = {1'b0, amt_ff};
         end
         S_SHORT: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {1'b0, amt_ff};
            alu_req.b  = {1'b0, cnt_ff};
         end
         S_DRAIN: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {1'b0, total_ff};
            alu_req.b  = {1'b0, amt_ff};
         end
         default: begin
            alu_req.op = ALU_ADD;
         end
      endcase
   end

   assign scan_hit    = pend_ff && alu_rsp.zero;
   assign scan_end    = (scan_ff >= used_ff);
   assign mem_rd_addr = scan_ff[IDX_W-1:0];

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      key_in        = key_ff;
      amt_in        = amt_ff;
      sum_in        = sum_ff;
      total_in      = total_ff;
      used_in       = used_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      hit_idx_in    = hit_idx_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_aout_in   = res_aout_ff;
      res_enough_in = res_enough_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_aout_in   = rsp_aout_ff;
      rsp_enough_in = rsp_enough_ff;
      rsp_total_in  = rsp_total_ff;
      mem_wr.en          = 1'b0;
      mem_wr.addr        = hit_idx_ff;
      mem_wr.entry.key   = key_ff;
      mem_wr.entry.count = alu_rsp.res[AMT_W-1:0];

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               action_in     = req_action;
               key_in        = req_item_key;
               amt_in        = req_amount;
               scan_in       = '0;
               pend_in       = 1'b0;
               res_status_in = ST_OK;
               res_aout_in   = '0;
               res_enough_in = 1'b0;
               case (req_action)
                  ACT_ADD:    state_in = S_SUM;
                  ACT_REMOVE: state_in = S_SCAN;
                  ACT_LOOKUP: state_in = S_SCAN;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_SUM: begin
            sum_in   = alu_rsp.res;
            state_in = S_CAP;
         end
         S_CAP: begin
            if (!alu_rsp.borrow && !alu_rsp.zero) begin
               res_status_in = ST_OVER;
               res_aout_in   = alu_rsp.res;
               state_in      = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // one read issued per cycle, its compare in the next cycle
            if (!scan_end) begin
               scan_in     = scan_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[IDX_W-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (scan_hit) begin
               pend_in    = 1'b0;
               hit_idx_in = pend_idx_ff;
               cnt_in     = mem_rd_entry.count;
               case (action_ff)
                  ACT_ADD:    state_in = S_MERGE;
                  ACT_REMOVE: state_in = S_TAKE;
                  default:    state_in = S_PEEK;
               endcase
            end else if (scan_end) begin
               if (action_ff == ACT_ADD) begin
                  if (used_ff >= CNT_W'(SLOTS)) begin
                     res_status_in = ST_FULL;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_APPEND;
                  end
               end else begin
                  res_status_in = ST_MISSING;
                  state_in      = S_DONE;
               end
            end
         end
         S_MERGE: begin
            mem_wr.en = 1'b1;
            total_in  = sum_ff[TOT_W-1:0];
            state_in  = S_DONE;
         end
         S_APPEND: begin
            mem_wr.en          = 1'b1;
            mem_wr.addr        = used_ff[IDX_W-1:0];
            mem_wr.entry.count = amt_ff;
            used_in            = used_ff + 1'b1;
            total_in           = sum_ff[TOT_W-1:0];
            state_in           = S_DONE;
         end
         S_TAKE: begin
            if (alu_rsp.borrow) begin
               state_in = S_SHORT;
            end else begin
               mem_wr.en = 1'b1;
               state_in  = S_DRAIN;
            end
         end
         S_SHORT: begin
            res_status_in = ST_SHORT;
            res_aout_in   = alu_rsp.res;
            state_in      = S_DONE;
         end
         S_DRAIN: begin
            total_in = alu_rsp.res[TOT_W-1:0];
            state_in = S_DONE;
         end
         S_PEEK: begin
            res_aout_in   = {1'b0, cnt_ff};
            res_enough_in = !alu_rsp.borrow;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_aout_in   = res_aout_ff;
               rsp_enough_in = res_enough_ff;
               rsp_total_in  = total_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         total_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         total_ff     <= total_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff     <= action_in;
      key_ff        <= key_in;
      amt_ff        <= amt_in;
      sum_ff        <= sum_in;
      scan_ff       <= scan_in;
      pend_idx_ff   <= pend_idx_in;
      hit_idx_ff    <= hit_idx_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_aout_ff   <= res_aout_in;
      res_enough_ff <= res_enough_in;
      rsp_status_ff <= rsp_status_in;
      rsp_aout_ff   <= rsp_aout_in;
      rsp_enough_ff <= rsp_enough_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_amount_out = rsp_aout_ff;
   assign rsp_has_enough = rsp_enough_ff;
   assign rsp_total_now  = rsp_total_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/keyed_count_table_with_quota.sv =====
// Top level of the keyed count table with a total-amount quota.
//
// Request channel (req_*): one word carries action, item_key and amount.
// Actions: add amount to a key (merge or append a slot), remove amount from
// a key, or look up the count of a key. Response channel (rsp_*): one word
// per request with status, amount_out, has_enough and total_now.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. CSR port (APB-style, csr_*): capacity at byte address 0.
// Capacity must be written only while the block is idle.
//
// Timing: a request word is taken only while the sequencer is idle. The
// key search reads the slot store one entry per cycle and ends at the first
// match or at the fill count; over-quota adds answer without a search. Once
// the response is registered the sequencer is idle again for the next one.
// A stalled response sits in the output register; the sequencer can take
// and work on the next request, and holds its result until the slot frees.
// Reset (synchronous): table empty, total zero, capacity 65535, no
// response pending. Slot contents are not cleared; only slots below the
// fill count are ever compared.
`default_nettype none

module keyed_count_table_with_quota (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [kctq_pkg::ACT_W-1:0]    req_action,
   input  logic [kctq_pkg::KEY_W-1:0]    req_item_key,
   input  logic [kctq_pkg::AMT_W-1:0]    req_amount,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [kctq_pkg::STAT_W-1:0]   rsp_status,
   output logic [kctq_pkg::AOUT_W-1:0]   rsp_amount_out,
   output logic                          rsp_has_enough,
   output logic [kctq_pkg::TOT_W-1:0]    rsp_total_now,
   // CSR port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import kctq_pkg::*;

   // Capacity register: address bit 2 clear selects it, anything above
   // is outside the map and reads zero.
   logic [TOT_W-1:0] capacity_ff, capacity_in;
   logic             cap_sel;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;
   mem_wr_type  mem_wr;
   logic [IDX_W-1:0] mem_rd_addr;
   entry_type   mem_rd_entry;

   assign cap_sel    = !csr_paddr[2];
   assign csr_pready = 1'b1;
   assign csr_prdata = cap_sel ? {16'd0, capacity_ff} : 32'd0;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_psel && csr_penable && csr_pwrite && cap_sel) begin
         capacity_in = csr_pwdata[TOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '1;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // sequencer with state, totals and the response register
   kctq_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_item_key   (req_item_key),
      .req_amount     (req_amount),
      .capacity       (capacity_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_amount_out (rsp_amount_out),
      .rsp_has_enough (rsp_has_enough),
      .rsp_total_now  (rsp_total_now),
      .alu_req        (alu_req),
      .alu_rsp        (alu_rsp),
      .mem_wr         (mem_wr),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_entry   (mem_rd_entry)
   );

   // one add/subtract unit serves key compare, quota check and updates
   kctq_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // slot store
   kctq_mem u_mem (
      .clock    (clock),
      .wr       (mem_wr),
      .rd_addr  (mem_rd_addr),
      .rd_entry (mem_rd_entry)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/kctq_checker.sv =====
// Port-level checks of the keyed count table, bound to the top level.
`default_nettype none

module kctq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [kctq_pkg::STAT_W-1:0]   rsp_status,
   input logic [kctq_pkg::AOUT_W-1:0]   rsp_amount_out,
   input logic                          rsp_has_enough,
   input logic [kctq_pkg::TOT_W-1:0]    rsp_total_now
);
   import kctq_pkg::*;

   // a stalled response holds its status, amount and total
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_amount_out) && $stable(rsp_total_now))
      else $error("stalled response word changed");

   // one request at a time: after a take the sequencer is busy
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // has_enough only with status OK, and the count fits 16 bits
   a_enough_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_enough |-> rsp_status == ST_OK && !rsp_amount_out[AOUT_W-1])
      else $error("has_enough with bad status or count");

   // full and missing carry no amount; codes above too-few never appear
   a_status_amt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_OVER
         || rsp_status == ST_SHORT || rsp_amount_out == '0)
         && (rsp_status == ST_OK || rsp_status == ST_OVER || rsp_status == ST_FULL
         || rsp_status == ST_MISSING || rsp_status == ST_SHORT))
      else $error("bad status or amount on response");

   // nothing pending right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind keyed_count_table_with_quota kctq_checker u_checker (.*);

`default_nettype wire
